// ===== rtl/btt_pkg.sv =====
// ----------------------------------------------------------------------------
// btt_pkg
// Types, codes and the microcode program of the beacon timer table.
// ----------------------------------------------------------------------------
package btt_pkg;

    // Request types.
    localparam logic [1:0] REQ_SET     = 2'd0;
    localparam logic [1:0] REQ_PROCESS = 2'd1;
    localparam logic [1:0] REQ_REALIGN = 2'd2;

    // Result kinds.
    localparam logic [1:0] RK_SET_OK = 2'd0;
    localparam logic [1:0] RK_FULL   = 2'd1;
    localparam logic [1:0] RK_FIRED  = 2'd2;
    localparam logic [1:0] RK_DONE   = 2'd3;

    // Configuration register indexes, decoded from paddr[2].
    localparam logic REG_MIN_SEP  = 1'b0;
    localparam logic REG_MAX_LEAD = 1'b1;

    // Most firings one process request may produce.
    localparam logic [3:0] MAX_FIRES = 4'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now;
        logic [15:0] interval;
        logic [15:0] start_offset;
        logic [7:0]  beacon_kind;
        logic [15:0] text_handle;
        logic [3:0]  free_slots;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  entry_index;
        logic [7:0]  beacon_kind_res;
        logic [15:0] text_handle_res;
        logic        last;
    } res_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] delay;
        logic [31:0] deadline;
        logic [7:0]  kind;
        logic [15:0] text;
    } entry_t;

    typedef struct packed {
        logic [15:0] min_sep;
        logic [15:0] max_lead;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_INC_I,
        OP_INC_J,
        OP_WRITE_NEW,
        OP_READ_I,
        OP_READ_J,
        OP_EMIT_DONE,
        OP_EMIT_SETOK,
        OP_EMIT_FULL,
        OP_EMIT_FIRE,
        OP_RESCHED,
        OP_FREE_I,
        OP_LOAD_BASE,
        OP_FIX_J
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IS_SET,
        C_IS_PROC,
        C_IS_REALIGN,
        C_I_END,
        C_J_END,
        C_FREE_I,
        C_NOT_ACTIVE_I,
        C_NOT_DUE,
        C_ONCE_I,
        C_STOP,
        C_NOT_EN_I,
        C_NOT_EN_J
    } cond_t;

    typedef logic [4:0] step_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Sequencer to datapath.
    typedef struct packed {
        uop_t op;
        logic take;
    } ctl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic is_set;
        logic is_proc;
        logic is_realign;
        logic i_end;
        logic j_end;
        logic free_i;
        logic active_i;
        logic en_i;
        logic en_j;
        logic due;
        logic once_i;
        logic stop;
    } stat_t;

    // Program steps.
    localparam step_t ST_FETCH     = 5'd0;
    localparam step_t ST_DISP_SET  = 5'd1;
    localparam step_t ST_DISP_PROC = 5'd2;
    localparam step_t ST_DISP_RAL  = 5'd3;
    localparam step_t ST_DONE      = 5'd4;
    localparam step_t ST_S_CHECK   = 5'd5;
    localparam step_t ST_S_FREE    = 5'd6;
    localparam step_t ST_S_NEXT    = 5'd7;
    localparam step_t ST_S_CLAIM   = 5'd8;
    localparam step_t ST_S_ACK     = 5'd9;
    localparam step_t ST_S_FULL    = 5'd10;
    localparam step_t ST_P_CHECK   = 5'd11;
    localparam step_t ST_P_STOP    = 5'd12;
    localparam step_t ST_P_READ    = 5'd13;
    localparam step_t ST_P_DUE     = 5'd14;
    localparam step_t ST_P_FIRE    = 5'd15;
    localparam step_t ST_P_ONCE    = 5'd16;
    localparam step_t ST_P_RESCHED = 5'd17;
    localparam step_t ST_P_FREE    = 5'd18;
    localparam step_t ST_P_NEXT    = 5'd19;
    localparam step_t ST_R_CHECK   = 5'd20;
    localparam step_t ST_R_EN      = 5'd21;
    localparam step_t ST_R_READ    = 5'd22;
    localparam step_t ST_R_BASE    = 5'd23;
    localparam step_t ST_J_CHECK   = 5'd24;
    localparam step_t ST_J_EN      = 5'd25;
    localparam step_t ST_J_READ    = 5'd26;
    localparam step_t ST_J_FIX     = 5'd27;
    localparam step_t ST_J_NEXT    = 5'd28;
    localparam step_t ST_R_NEXT    = 5'd29;

    function automatic ucode_t uw(input uop_t op, input cond_t cnd, input step_t tgt);
        ucode_t w;
        w.op     = op;
        w.cond   = cnd;
        w.target = tgt;
        return w;
    endfunction

    function automatic logic is_emit(input uop_t op);
        return (op == OP_EMIT_DONE) || (op == OP_EMIT_SETOK) ||
               (op == OP_EMIT_FULL) || (op == OP_EMIT_FIRE);
    endfunction

    // The control store. A taken condition jumps to the target, otherwise the
    // step counter advances by one.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            ST_FETCH:     w = uw(OP_ACCEPT,     C_NEVER,        ST_FETCH);
            ST_DISP_SET:  w = uw(OP_NOP,        C_IS_SET,       ST_S_CHECK);
            ST_DISP_PROC: w = uw(OP_NOP,        C_IS_PROC,      ST_P_CHECK);
            ST_DISP_RAL:  w = uw(OP_NOP,        C_IS_REALIGN,   ST_R_CHECK);
            ST_DONE:      w = uw(OP_EMIT_DONE,  C_ALWAYS,       ST_FETCH);
            ST_S_CHECK:   w = uw(OP_NOP,        C_I_END,        ST_S_FULL);
            ST_S_FREE:    w = uw(OP_NOP,        C_FREE_I,       ST_S_CLAIM);
            ST_S_NEXT:    w = uw(OP_INC_I,      C_ALWAYS,       ST_S_CHECK);
            ST_S_CLAIM:   w = uw(OP_WRITE_NEW,  C_NEVER,        ST_FETCH);
            ST_S_ACK:     w = uw(OP_EMIT_SETOK, C_ALWAYS,       ST_FETCH);
            ST_S_FULL:    w = uw(OP_EMIT_FULL,  C_ALWAYS,       ST_FETCH);
            ST_P_CHECK:   w = uw(OP_NOP,        C_I_END,        ST_DONE);
            ST_P_STOP:    w = uw(OP_NOP,        C_STOP,         ST_DONE);
            ST_P_READ:    w = uw(OP_READ_I,     C_NOT_ACTIVE_I, ST_P_NEXT);
            ST_P_DUE:     w = uw(OP_NOP,        C_NOT_DUE,      ST_P_NEXT);
            ST_P_FIRE:    w = uw(OP_EMIT_FIRE,  C_NEVER,        ST_FETCH);
            ST_P_ONCE:    w = uw(OP_NOP,        C_ONCE_I,       ST_P_FREE);
            ST_P_RESCHED: w = uw(OP_RESCHED,    C_ALWAYS,       ST_P_NEXT);
            ST_P_FREE:    w = uw(OP_FREE_I,     C_NEVER,        ST_FETCH);
            ST_P_NEXT:    w = uw(OP_INC_I,      C_ALWAYS,       ST_P_CHECK);
            ST_R_CHECK:   w = uw(OP_NOP,        C_I_END,        ST_DONE);
            ST_R_EN:      w = uw(OP_NOP,        C_NOT_EN_I,     ST_R_NEXT);
            ST_R_READ:    w = uw(OP_READ_I,     C_NEVER,        ST_FETCH);
            ST_R_BASE:    w = uw(OP_LOAD_BASE,  C_NEVER,        ST_FETCH);
            ST_J_CHECK:   w = uw(OP_NOP,        C_J_END,        ST_R_NEXT);
            ST_J_EN:      w = uw(OP_NOP,        C_NOT_EN_J,     ST_J_NEXT);
            ST_J_READ:    w = uw(OP_READ_J,     C_NEVER,        ST_FETCH);
            ST_J_FIX:     w = uw(OP_FIX_J,      C_NEVER,        ST_FETCH);
            ST_J_NEXT:    w = uw(OP_INC_J,      C_ALWAYS,       ST_J_CHECK);
            ST_R_NEXT:    w = uw(OP_INC_I,      C_ALWAYS,       ST_R_CHECK);
            default:      w = uw(OP_NOP,        C_ALWAYS,       ST_FETCH);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/beacon_timer_table_unit.sv =====
// ----------------------------------------------------------------------------
// beacon_timer_table_unit
// Table of periodic beacon timers run by a microcoded sequencer.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_stall    req_t: one request beat
//   res      out        res_valid / res_stall    res_t: one result beat
//   apb      in         psel penable pwrite      min_separation, max_lead
//
// One request at a time. A request is taken only at the fetch step, and the
// dispatch steps follow it. Set scans the entries for a free one, process
// checks each entry for a due firing, and realign compares each enabled entry
// with every later enabled one, all stepped through the control store.
// Reset clears the flags, the scan counters and the result valid bit; entry
// contents stay undefined and are used only after a set has written them.
// res_stall holds the sequencer only at a step that emits a result beat.
// ----------------------------------------------------------------------------
module beacon_timer_table_unit
    import btt_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctl_t        ctl;
    stat_t       stat;
    cfg_t        cfg;
    logic [15:0] min_sep_reg;
    logic [15:0] max_lead_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sep_reg  <= 16'd30;
            max_lead_reg <= 16'd3600;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MIN_SEP:  min_sep_reg  <= pwdata[15:0];
                REG_MAX_LEAD: max_lead_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MIN_SEP:  prdata = {16'd0, min_sep_reg};
            REG_MAX_LEAD: prdata = {16'd0, max_lead_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.min_sep  = min_sep_reg;
    assign cfg.max_lead = max_lead_reg;

    assign req_stall = !ctl.take;

    btt_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    btt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req       (req),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef NO_ASSERTIONS
    // After a request beat the sequencer leaves the fetch step.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken twice in a row");

    // A result beat is never issued into an occupied, stalled output register.
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        is_emit(ctl.op) |-> !stat.out_busy)
        else $error("result emitted while output is stalled");

    // A firing needs an active, due entry, slots left and firings left.
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_EMIT_FIRE) |-> (stat.due && stat.active_i && !stat.stop))
        else $error("beacon fired without being eligible");
`endif

endmodule

// ===== rtl/btt_seq.sv =====
// ----------------------------------------------------------------------------
// btt_seq
// Step counter and control store; holds on a missing input or a full output.
// ----------------------------------------------------------------------------
module btt_seq
    import btt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   hold;
    logic   taken;

    always_comb
    begin
        word  = ucode_rom(step_reg);
        hold  = ((word.op == OP_ACCEPT) && !stat.in_valid) ||
                (is_emit(word.op) && stat.out_busy);
        case (word.cond)
            C_NEVER:        taken = 1'b0;
            C_ALWAYS:       taken = 1'b1;
            C_IS_SET:       taken = stat.is_set;
            C_IS_PROC:      taken = stat.is_proc;
            C_IS_REALIGN:   taken = stat.is_realign;
            C_I_END:        taken = stat.i_end;
            C_J_END:        taken = stat.j_end;
            C_FREE_I:       taken = stat.free_i;
            C_NOT_ACTIVE_I: taken = !stat.active_i;
            C_NOT_DUE:      taken = !stat.due;
            C_ONCE_I:       taken = stat.once_i;
            C_STOP:         taken = stat.stop;
            C_NOT_EN_I:     taken = !stat.en_i;
            C_NOT_EN_J:     taken = !stat.en_j;
            default:        taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + 5'd1;
        end
    end

    always_comb
    begin
        ctl.op   = hold ? OP_NOP : word.op;
        ctl.take = (word.op == OP_ACCEPT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/btt_dp.sv =====
// ----------------------------------------------------------------------------
// btt_dp
// Datapath: request latch, entry memory, per-entry flags, scan counters,
// time arithmetic and the result register.
// ----------------------------------------------------------------------------
module btt_dp
    import btt_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctl_t  ctl,
    input  cfg_t  cfg,
    input  logic  req_valid,
    input  req_t  req,
    output stat_t stat,
    output logic  res_valid,
    input  logic  res_stall,
    output res_t  res
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    entry_t mem [ENTRIES];
    entry_t rd_reg;

    req_t            req_reg;
    logic [31:0]     base_reg;
    logic [CW-1:0]   i_reg;
    logic [CW-1:0]   i_next;
    logic [CW-1:0]   j_reg;
    logic [CW-1:0]   j_next;
    logic [3:0]      n_reg;
    logic [3:0]      n_next;
    logic [3:0]      slots_reg;
    logic [3:0]      slots_next;
    logic [ENTRIES-1:0] used_reg;
    logic [ENTRIES-1:0] used_next;
    logic [ENTRIES-1:0] en_reg;
    logic [ENTRIES-1:0] en_next;
    logic [ENTRIES-1:0] once_reg;
    logic [ENTRIES-1:0] once_next;
    logic            res_valid_reg;
    logic            res_valid_next;
    res_t            res_reg;

    logic [AW-1:0]   ia;
    logic [AW-1:0]   ja;
    logic            we;
    logic [AW-1:0]   wa;
    entry_t          wd;
    logic            re;
    logic [AW-1:0]   ra;
    logic [31:0]     lead;
    logic [31:0]     gap;
    logic [31:0]     gap_mag;
    logic            stale;
    logic            close;
    logic [31:0]     restart;
    logic            emit;

    assign ia = i_reg[AW-1:0];
    assign ja = j_reg[AW-1:0];

    // Time differences are taken as 32-bit two's complement values.
    always_comb
    begin
        restart = req_reg.now + 32'(rd_reg.delay);
        lead    = rd_reg.deadline - req_reg.now;
        stale   = lead[31] || (lead > 32'(cfg.max_lead));
        gap     = rd_reg.deadline - base_reg;
        gap_mag = gap[31] ? (32'd0 - gap) : gap;
        close   = (gap != 32'h8000_0000) && (gap_mag < 32'(cfg.min_sep));
    end

    always_comb
    begin
        stat.in_valid   = req_valid;
        stat.out_busy   = res_valid_reg && res_stall;
        stat.is_set     = (req_reg.req_type == REQ_SET);
        stat.is_proc    = (req_reg.req_type == REQ_PROCESS);
        stat.is_realign = (req_reg.req_type == REQ_REALIGN);
        stat.i_end      = (i_reg == CW'(ENTRIES));
        stat.j_end      = (j_reg == CW'(ENTRIES));
        stat.free_i     = !used_reg[ia];
        stat.active_i   = used_reg[ia] && en_reg[ia];
        stat.en_i       = en_reg[ia];
        stat.en_j       = en_reg[ja];
        stat.once_i     = once_reg[ia];
        stat.stop       = (slots_reg == 4'd0) || (n_reg == MAX_FIRES);
        stat.due        = !((req_reg.now - rd_reg.deadline) >= 32'h8000_0000);
    end

    // Memory port selection and flag, counter updates.
    always_comb
    begin
        we         = 1'b0;
        wa         = ia;
        wd         = rd_reg;
        re         = 1'b0;
        ra         = ia;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        slots_next = slots_reg;
        used_next  = used_reg;
        en_next    = en_reg;
        once_next  = once_reg;
        case (ctl.op)
            OP_ACCEPT:
            begin
                i_next     = '0;
                j_next     = '0;
                n_next     = 4'd0;
                slots_next = req.free_slots;
            end
            OP_INC_I:
            begin
                i_next = i_reg + CW'(1);
            end
            OP_INC_J:
            begin
                j_next = j_reg + CW'(1);
            end
            OP_WRITE_NEW:
            begin
                we              = 1'b1;
                wd.period       = req_reg.interval;
                wd.delay        = req_reg.start_offset;
                wd.deadline     = req_reg.now + 32'(req_reg.start_offset);
                wd.kind         = req_reg.beacon_kind;
                wd.text         = req_reg.text_handle;
                used_next[ia]   = 1'b1;
                en_next[ia]     = 1'b1;
                once_next[ia]   = (req_reg.interval == 16'd0);
            end
            OP_READ_I:
            begin
                re = 1'b1;
            end
            OP_READ_J:
            begin
                re = 1'b1;
                ra = ja;
            end
            OP_EMIT_FIRE:
            begin
                n_next     = n_reg + 4'd1;
                slots_next = slots_reg - 4'd1;
            end
            OP_RESCHED:
            begin
                we          = 1'b1;
                wd.deadline = req_reg.now + 32'(rd_reg.period);
            end
            OP_FREE_I:
            begin
                used_next[ia] = 1'b0;
                en_next[ia]   = 1'b0;
                once_next[ia] = 1'b0;
            end
            OP_LOAD_BASE:
            begin
                we          = stale;
                wd.deadline = restart;
                j_next      = i_reg + CW'(1);
            end
            OP_FIX_J:
            begin
                we          = close;
                wa          = ja;
                wd.deadline = restart;
            end
            default:
            begin
            end
        endcase
    end

    assign emit = is_emit(ctl.op);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_ACCEPT)
        begin
            req_reg <= req;
        end
        if (ctl.op == OP_LOAD_BASE)
        begin
            base_reg <= stale ? restart : rd_reg.deadline;
        end
        if (emit)
        begin
            res_reg.result_kind     <= RK_DONE;
            res_reg.entry_index     <= 3'd0;
            res_reg.beacon_kind_res <= 8'd0;
            res_reg.text_handle_res <= 16'd0;
            res_reg.last            <= 1'b1;
            case (ctl.op)
                OP_EMIT_SETOK:
                begin
                    res_reg.result_kind <= RK_SET_OK;
                    res_reg.entry_index <= 3'(i_reg);
                end
                OP_EMIT_FULL:
                begin
                    res_reg.result_kind <= RK_FULL;
                end
                OP_EMIT_FIRE:
                begin
                    res_reg.result_kind     <= RK_FIRED;
                    res_reg.entry_index     <= 3'(i_reg);
                    res_reg.beacon_kind_res <= rd_reg.kind;
                    res_reg.text_handle_res <= rd_reg.text;
                    res_reg.last            <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= 4'd0;
            slots_reg     <= 4'd0;
            used_reg      <= '0;
            en_reg        <= '0;
            once_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            slots_reg     <= slots_next;
            used_reg      <= used_next;
            en_reg        <= en_next;
            once_reg      <= once_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
